// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge outside reset
`define BMSM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every rising edge, reset included
`define BMSM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bmsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bmsm_pkg;

   localparam int POS_W      = 7;
   localparam int SIZE_W     = 8;
   localparam int THR_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int N_RES      = 3;

   localparam logic [SIZE_W-1:0] GRID_SIZE_RESET      = 8'd100;
   localparam logic [SIZE_W-1:0] MIN_SIZE             = 8'd3;
   localparam logic [THR_W-1:0]  WALL_THRESHOLD_RESET = 4'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH     = 2'd0,
      CSR_GRID_HEIGHT    = 2'd1,
      CSR_WALL_THRESHOLD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic r_ge1;
      logic r_ge2;
      logic c_ge1;
      logic c_ge2;
      logic c_last;
      logic r_last;
   } pos_flags_type;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      pos_flags_type    flags;
   } pos_type;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             wall;
      logic             done;
   } result_type;

   typedef struct packed {
      logic [N_RES-1:0]       valid;
      result_type [N_RES-1:0] item;
   } bundle_type;

endpackage

`default_nettype wire

// ===== design/bmsm_line_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

// two previous rows per column: bit 1 two rows up, bit 0 one row up
module bmsm_line_buf #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [1:0]         rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [1:0]    wr_data
);

   logic [1:0] mem [DEPTH];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/bmsm_window.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmsm_window #(
   parameter int AW = 7
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire logic                      in_wall,
   input  wire bmsm_pkg::pos_type         in_pos,
   input  wire logic [AW-1:0]             in_idx,
   input  wire logic [1:0]                rd_data,
   input  wire logic [bmsm_pkg::THR_W-1:0] threshold,
   output logic                           wr_en,
   output logic [AW-1:0]                  wr_addr,
   output logic [1:0]                     wr_data,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output bmsm_pkg::bundle_type           out_bundle
);

   `include "assert_macros.svh"

   localparam int POS_W = bmsm_pkg::POS_W;

   function automatic logic [1:0] ones3(input logic [2:0] v);
      ones3 = {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
   endfunction

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_wall_ff, s1_wall_in;
   bmsm_pkg::pos_type    s1_pos_ff, s1_pos_in;
   logic [AW-1:0]        s1_idx_ff, s1_idx_in;
   logic [5:0]           window_ff, window_in;

   logic [2:0]           col3, prev1, prev2;
   logic [3:0]           window_walls;
   logic                 smoothed;
   logic                 advance;
   bmsm_pkg::bundle_type bundle;

   // bit 0 two rows up, bit 1 one row up, bit 2 current row
   assign col3  = {s1_wall_ff, rd_data[0], rd_data[1]};
   assign prev1 = window_ff[2:0];
   assign prev2 = window_ff[5:3];

   assign window_walls = {2'b00, ones3(col3)} + {2'b00, ones3(prev1)}
                       + {2'b00, ones3(prev2)};

   always_comb begin
      if (s1_pos_ff.flags.r_ge2 && s1_pos_ff.flags.c_ge2) begin
         smoothed = (window_walls >= threshold);
      end else begin
         // window touches the border: centre passes through
         smoothed = prev1[1];
      end
   end

   always_comb begin
      bundle = '0;
      if (s1_pos_ff.flags.r_ge1 && s1_pos_ff.flags.c_ge1) begin
         bundle.valid[0]     = 1'b1;
         bundle.item[0].row  = s1_pos_ff.row - POS_W'(1);
         bundle.item[0].col  = s1_pos_ff.col - POS_W'(1);
         bundle.item[0].wall = smoothed;
         if (s1_pos_ff.flags.c_last) begin
            // right border cell of the row above
            bundle.valid[1]     = 1'b1;
            bundle.item[1].row  = s1_pos_ff.row - POS_W'(1);
            bundle.item[1].col  = s1_pos_ff.col;
            bundle.item[1].wall = col3[1];
         end
      end
      if (s1_pos_ff.flags.r_last) begin
         bundle.valid[2]     = 1'b1;
         bundle.item[2].row  = s1_pos_ff.row;
         bundle.item[2].col  = s1_pos_ff.col;
         bundle.item[2].wall = s1_wall_ff;
         bundle.item[2].done = s1_pos_ff.flags.c_last;
      end
   end

   assign advance    = s1_valid_ff && (!(|bundle.valid) || out_ready);
   assign in_ready   = !s1_valid_ff || advance;
   assign out_valid  = s1_valid_ff && (|bundle.valid);
   assign out_bundle = bundle;

   assign wr_en   = advance;
   assign wr_addr = s1_idx_ff;
   assign wr_data = {rd_data[0], s1_wall_ff};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_wall_in  = s1_wall_ff;
      s1_pos_in   = s1_pos_ff;
      s1_idx_in   = s1_idx_ff;
      window_in   = window_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
         window_in   = {prev1, col3};
      end
      if (in_valid && in_ready) begin
         s1_valid_in = 1'b1;
         s1_wall_in  = in_wall;
         s1_pos_in   = in_pos;
         s1_idx_in   = in_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         window_ff   <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         window_ff   <= window_in;
      end
      s1_wall_ff <= s1_wall_in;
      s1_pos_ff  <= s1_pos_in;
      s1_idx_ff  <= s1_idx_in;
   end

   `BMSM_ASSERT(a_right_border_after_centre, clock, reset,
      out_valid && out_bundle.valid[1] |-> out_bundle.valid[0],
      "right border result without its neighbour")

endmodule

`default_nettype wire

// ===== design/bmsm_serial.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmsm_serial (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire bmsm_pkg::bundle_type in_bundle,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output bmsm_pkg::result_type      rsp_item
);

   `include "assert_macros.svh"

   localparam int N_RES = bmsm_pkg::N_RES;

   logic [N_RES-1:0]                 mask_ff, mask_in;
   bmsm_pkg::result_type [N_RES-1:0] items_ff, items_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   bmsm_pkg::result_type             rsp_item_ff, rsp_item_in;

   logic                             take;
   logic                             move;
   logic                             load;
   logic [N_RES-1:0]                 pick;
   logic [N_RES-1:0]                 rest;
   bmsm_pkg::result_type             picked;

   assign take = !rsp_valid_ff || rsp_ready;
   assign move = take && (|mask_ff);

   // lowest pending slot goes first
   always_comb begin
      pick   = '0;
      picked = items_ff[0];
      if (mask_ff[0]) begin
         pick[0] = move;
         picked  = items_ff[0];
      end else if (mask_ff[1]) begin
         pick[1] = move;
         picked  = items_ff[1];
      end else if (mask_ff[2]) begin
         pick[2] = move;
         picked  = items_ff[2];
      end
   end

   assign rest     = mask_ff & ~pick;
   assign in_ready = (rest == '0);
   assign load     = in_valid && in_ready;

   always_comb begin
      mask_in      = rest;
      items_in     = items_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      if (load) begin
         mask_in  = in_bundle.valid;
         items_in = in_bundle.item;
      end
      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = picked;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      items_ff    <= items_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `BMSM_ASSERT(a_bundle_drains, clock, reset,
      move && (rest == '0) && !load |=> mask_ff == '0,
      "pending results left after the last one moved out")

endmodule

`default_nettype wire

// ===== design/binary_majority_smoothing.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 3x3 majority smoothing of a wall/floor grid, one pass per frame.
// req_ channel: one cell per request in raster order, req_wall_in 1 = wall.
// rsp_ channel: smoothed cells with their row and column; rsp_frame_done
// marks the last cell of the grid. Interior cells become wall when the
// walls in their 3x3 window reach wall_threshold; border cells pass through.
// csr_ channel: index 0 grid width, 1 grid height, 2 wall threshold. Sizes
// are clamped to 3..MAX_WIDTH / 3..MAX_HEIGHT; writing a size restarts the
// frame at row 0, column 0. Write only while the block is idle.
// A cell is reported once the request one row and one column later has
// arrived; results pass the window register, a pending slot and the output
// register. A request gives up to three results (right border, last row);
// while rsp_ready is high the rate is one request per cycle inside the grid
// and one result per cycle overall, set by the single result port.
// Line buffer: one memory of MAX_WIDTH entries, read when a request is taken
// and written back when it leaves the window register. Reset clears control
// state and loads the register defaults (100 x 100, threshold 5). When
// rsp_ready is low, results wait in the output register and pending slots,
// and req_ready falls.
module binary_majority_smoothing #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_wall_in,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [bmsm_pkg::POS_W-1:0]               rsp_out_row,
   output logic [bmsm_pkg::POS_W-1:0]               rsp_out_col,
   output logic                                     rsp_wall_out,
   output logic                                     rsp_frame_done,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [bmsm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [bmsm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   `include "assert_macros.svh"

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int POS_W = bmsm_pkg::POS_W;
   localparam int THR_W = bmsm_pkg::THR_W;

   logic [bmsm_pkg::SIZE_W-1:0] grid_width_ff, grid_width_in;
   logic [bmsm_pkg::SIZE_W-1:0] grid_height_ff, grid_height_in;
   logic [THR_W-1:0]            wall_threshold_ff, wall_threshold_in;
   logic [CW-1:0]               col_ff, col_in;
   logic [RW-1:0]               row_ff, row_in;

   logic [CW-1:0]               col_last;
   logic [RW-1:0]               row_last;
   logic                        accept;
   bmsm_pkg::pos_type           pos;

   logic [1:0]                  rd_data;
   logic                        wr_en;
   logic [CW-1:0]               wr_addr;
   logic [1:0]                  wr_data;

   logic                        win_valid;
   logic                        win_ready;
   bmsm_pkg::bundle_type        bundle;
   bmsm_pkg::result_type        rsp_item;

   // clamped last column and last row
   always_comb begin
      if (grid_width_ff < bmsm_pkg::MIN_SIZE) begin
         col_last = CW'(bmsm_pkg::MIN_SIZE - 8'd1);
      end else if (32'(grid_width_ff) > MAX_WIDTH) begin
         col_last = CW'(MAX_WIDTH - 1);
      end else begin
         col_last = CW'(grid_width_ff - 8'd1);
      end
      if (grid_height_ff < bmsm_pkg::MIN_SIZE) begin
         row_last = RW'(bmsm_pkg::MIN_SIZE - 8'd1);
      end else if (32'(grid_height_ff) > MAX_HEIGHT) begin
         row_last = RW'(MAX_HEIGHT - 1);
      end else begin
         row_last = RW'(grid_height_ff - 8'd1);
      end
   end

   assign accept = req_valid && req_ready;

   always_comb begin
      pos.row          = POS_W'(row_ff);
      pos.col          = POS_W'(col_ff);
      pos.flags.r_ge1  = (row_ff != '0);
      pos.flags.r_ge2  = (row_ff > RW'(1));
      pos.flags.c_ge1  = (col_ff != '0);
      pos.flags.c_ge2  = (col_ff > CW'(1));
      pos.flags.c_last = (col_ff == col_last);
      pos.flags.r_last = (row_ff == row_last);
   end

   always_comb begin
      grid_width_in     = grid_width_ff;
      grid_height_in    = grid_height_ff;
      wall_threshold_in = wall_threshold_ff;
      col_in            = col_ff;
      row_in            = row_ff;
      if (accept) begin
         if (col_ff == col_last) begin
            col_in = '0;
            row_in = (row_ff == row_last) ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      if (csr_valid && csr_ready) begin
         case (bmsm_pkg::csr_index_type'(csr_index))
            bmsm_pkg::CSR_GRID_WIDTH: begin
               grid_width_in = csr_wdata;
               col_in        = '0;
               row_in        = '0;
            end
            bmsm_pkg::CSR_GRID_HEIGHT: begin
               grid_height_in = csr_wdata;
               col_in         = '0;
               row_in         = '0;
            end
            bmsm_pkg::CSR_WALL_THRESHOLD: begin
               wall_threshold_in = csr_wdata[THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff     <= bmsm_pkg::GRID_SIZE_RESET;
         grid_height_ff    <= bmsm_pkg::GRID_SIZE_RESET;
         wall_threshold_ff <= bmsm_pkg::WALL_THRESHOLD_RESET;
         col_ff            <= '0;
         row_ff            <= '0;
      end else begin
         grid_width_ff     <= grid_width_in;
         grid_height_ff    <= grid_height_in;
         wall_threshold_ff <= wall_threshold_in;
         col_ff            <= col_in;
         row_ff            <= row_in;
      end
   end

   assign csr_ready = 1'b1;

   bmsm_line_buf #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_buf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   bmsm_window #(
      .AW (CW)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_wall    (req_wall_in),
      .in_pos     (pos),
      .in_idx     (col_ff),
      .rd_data    (rd_data),
      .threshold  (wall_threshold_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .out_valid  (win_valid),
      .out_ready  (win_ready),
      .out_bundle (bundle)
   );

   bmsm_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (win_valid),
      .in_ready  (win_ready),
      .in_bundle (bundle),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_out_row    = rsp_item.row;
   assign rsp_out_col    = rsp_item.col;
   assign rsp_wall_out   = rsp_item.wall;
   assign rsp_frame_done = rsp_item.done;

   `BMSM_ASSERT(a_col_in_grid, clock, reset, col_ff <= col_last,
      "column count beyond the last column")
   `BMSM_ASSERT(a_row_in_grid, clock, reset, row_ff <= row_last,
      "row count beyond the last row")

endmodule

`default_nettype wire
